// ----- hdl/mac_rx_filter_byte_budget_queue_top_defines.svh -----
// Assertion macros used by the checker file of the MAC ingress filter.
`ifndef MAC_RX_FILTER_BYTE_BUDGET_QUEUE_TOP_DEFINES_SVH
`define MAC_RX_FILTER_BYTE_BUDGET_QUEUE_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MRFBQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MRFBQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/mrfbq_pkg.sv -----
// Types and constants of the MAC ingress filter with byte-budgeted descriptor queue.
package mrfbq_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;

    localparam int ADDR_W = 16;
    localparam int LEN_W  = 12;
    localparam int TAG_W  = 16;
    localparam int BYTE_W = 16;
    localparam int DROP_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [ADDR_W-1:0] NODE_ADDR_RST  = 16'h0000;
    localparam logic [ADDR_W-1:0] BCAST_ADDR_RST = 16'hFFFF;
    localparam logic [BYTE_W-1:0] CAPACITY_RST   = 16'd16384;

    typedef enum logic [1:0] {
        CMD_PHY_FRAME    = 2'd0,
        CMD_ROUTE_FRAME  = 2'd1,
        CMD_SERVICE_DONE = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ACT_QUEUED = 3'd0,
        ACT_ROUTER = 3'd1,
        ACT_PHYS   = 3'd2,
        ACT_FILTER = 3'd3,
        ACT_DROP   = 3'd4,
        ACT_IDLE   = 3'd5
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NODE_ADDR  = 2'd0,
        CFG_BCAST_ADDR = 2'd1,
        CFG_PROMISC    = 2'd2,
        CFG_CAPACITY   = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]        command;
        logic [ADDR_W-1:0] dest_address;
        logic [LEN_W-1:0]  frame_length;
        logic [TAG_W-1:0]  frame_tag;
    } in_item_t;

    typedef struct packed {
        logic [2:0]        action;
        logic [TAG_W-1:0]  out_tag;
        logic [LEN_W-1:0]  out_length;
        logic              start_service;
        logic              router_busy;
        logic [BYTE_W-1:0] queued_bytes;
        logic [DROP_W-1:0] full_drops;
    } out_item_t;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [LEN_W-1:0] len;
    } desc_t;

endpackage

// ----- hdl/mrfbq_desc_mem.sv -----
// Descriptor store: one write port, one read port with registered read data.
module mrfbq_desc_mem
    import mrfbq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  desc_t         wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output desc_t         rd_data
);

    desc_t mem [QUEUE_DEPTH];
    desc_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/mac_rx_filter_byte_budget_queue_top.sv -----
// Top level of the MAC ingress filter with byte-budgeted descriptor queue.
//
//  channel  direction  handshake              payload
//  in       sink       in_valid / in_stall    in_data  (in_item_t)
//  out      source     out_valid / out_stall  out_data (out_item_t)
//  cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per cycle sustained while out is not stalled; each result is registered
// in the decide stage, then in the output register.
// A pop reads the descriptor store when its item is taken; in the decide stage its tag
// and length leave the store's read register and the length is taken off the byte total.
// The popped length is subtracted from the byte total in the cycle after the pop.
// Reset is asynchronous; the store needs no clearing pass.
// A stall on out holds both stages and backs up into in_stall.
module mac_rx_filter_byte_budget_queue_top
    import mrfbq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // configuration
    logic [ADDR_W-1:0] node_addr_reg;
    logic [ADDR_W-1:0] bcast_addr_reg;
    logic              promisc_reg;
    logic [BYTE_W-1:0] capacity_reg;

    // queue control state
    logic              busy_reg, busy_next;
    logic [BYTE_W-1:0] used_reg, used_next;
    logic              sub_pend_reg, sub_pend_next;
    logic [AW-1:0]     head_reg, head_next;
    logic [AW-1:0]     tail_reg, tail_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [DROP_W-1:0] drops_reg, drops_next;

    // decide stage and output register
    logic              p_valid_reg, p_valid_next;
    logic              p_pop_reg, p_pop_next;
    out_item_t         p_res_reg, p_res_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_data_reg, out_data_next;

    logic              accept;
    logic              p_move;
    logic [BYTE_W-1:0] used_eff;
    logic              addr_match;
    logic              mem_we;
    logic              mem_re;
    desc_t             mem_wdata;
    desc_t             mem_rdata;

    mrfbq_desc_mem #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_desc_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (tail_reg),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (head_reg),
        .rd_data (mem_rdata)
    );

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_addr_reg  <= NODE_ADDR_RST;
            bcast_addr_reg <= BCAST_ADDR_RST;
            promisc_reg    <= 1'b0;
            capacity_reg   <= CAPACITY_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_NODE_ADDR:  node_addr_reg  <= cfg_data;
                CFG_BCAST_ADDR: bcast_addr_reg <= cfg_data;
                CFG_PROMISC:    promisc_reg    <= cfg_data[0];
                CFG_CAPACITY:   capacity_reg   <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign p_move   = p_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = p_valid_reg && !p_move;
    assign accept   = in_valid && !in_stall;

    // fold in the length popped last cycle
    assign used_eff   = sub_pend_reg ? (used_reg - BYTE_W'(mem_rdata.len)) : used_reg;
    assign addr_match = (in_data.dest_address == node_addr_reg)
                     || (in_data.dest_address == bcast_addr_reg) || promisc_reg;

    always_comb
    begin
        busy_next     = busy_reg;
        used_next     = used_eff;
        sub_pend_next = 1'b0;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        drops_next    = drops_reg;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_wdata.tag = in_data.frame_tag;
        mem_wdata.len = in_data.frame_length;
        p_pop_next    = 1'b0;
        p_valid_next  = p_valid_reg && !p_move;
        p_res_next    = p_res_reg;

        if (accept)
        begin
            p_valid_next             = 1'b1;
            p_res_next.action        = ACT_FILTER;
            p_res_next.out_tag       = '0;
            p_res_next.out_length    = '0;
            p_res_next.start_service = 1'b0;
            case (cmd_t'(in_data.command))
                CMD_ROUTE_FRAME:
                begin
                    p_res_next.action     = ACT_PHYS;
                    p_res_next.out_tag    = in_data.frame_tag;
                    p_res_next.out_length = in_data.frame_length;
                end
                CMD_SERVICE_DONE:
                begin
                    if (count_reg != '0)
                    begin
                        // tag, length and byte total are filled in from the read data
                        mem_re                   = 1'b1;
                        p_pop_next               = 1'b1;
                        sub_pend_next            = 1'b1;
                        head_next = (head_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
                        count_next               = count_reg - 1'b1;
                        busy_next                = 1'b1;
                        p_res_next.action        = ACT_ROUTER;
                        p_res_next.start_service = 1'b1;
                    end
                    else
                    begin
                        busy_next         = 1'b0;
                        p_res_next.action = ACT_IDLE;
                    end
                end
                CMD_PHY_FRAME:
                begin
                    if (!addr_match)
                    begin
                        p_res_next.action = ACT_FILTER;
                    end
                    else if (!busy_reg && count_reg == '0)
                    begin
                        busy_next                = 1'b1;
                        p_res_next.action        = ACT_ROUTER;
                        p_res_next.out_tag       = in_data.frame_tag;
                        p_res_next.out_length    = in_data.frame_length;
                        p_res_next.start_service = 1'b1;
                    end
                    else if (({1'b0, used_eff} + (BYTE_W + 1)'(in_data.frame_length))
                             < {1'b0, capacity_reg}
                             && count_reg != CW'(QUEUE_DEPTH))
                    begin
                        mem_we            = 1'b1;
                        tail_next = (tail_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
                        count_next        = count_reg + 1'b1;
                        used_next         = used_eff + BYTE_W'(in_data.frame_length);
                        p_res_next.action = ACT_QUEUED;
                    end
                    else
                    begin
                        if (drops_reg != '1)
                        begin
                            drops_next = drops_reg + 1'b1;
                        end
                        p_res_next.action = ACT_DROP;
                    end
                end
                default:
                begin
                    // unused command: no result, no state change
                    p_valid_next = 1'b0;
                end
            endcase
            p_res_next.router_busy  = busy_next;
            p_res_next.queued_bytes = used_next;
            p_res_next.full_drops   = drops_next;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        if (p_move)
        begin
            out_valid_next = 1'b1;
            out_data_next  = p_res_reg;
            if (p_pop_reg)
            begin
                out_data_next.out_tag      = mem_rdata.tag;
                out_data_next.out_length   = mem_rdata.len;
                out_data_next.queued_bytes = p_res_reg.queued_bytes
                                           - BYTE_W'(mem_rdata.len);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            used_reg      <= '0;
            sub_pend_reg  <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            drops_reg     <= '0;
            p_valid_reg   <= 1'b0;
            p_pop_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            used_reg      <= used_next;
            sub_pend_reg  <= sub_pend_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            drops_reg     <= drops_next;
            p_valid_reg   <= p_valid_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                p_pop_reg <= p_pop_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p_res_reg    <= p_res_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- hdl/mrfbq_checker.sv -----
// Port-level checks of the MAC ingress filter, bound to the top level.
`include "mac_rx_filter_byte_budget_queue_top_defines.svh"

module mrfbq_checker
    import mrfbq_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_data
);

    `MRFBQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled item changed")
    `MRFBQ_ASSERT_NOW(a_start_busy, clk, rst_n, out_valid && out_data.start_service, out_data.router_busy, "service start without busy flag")
    `MRFBQ_ASSERT_NOW(a_idle_empty, clk, rst_n, out_valid && out_data.action == ACT_IDLE, !out_data.router_busy && out_data.queued_bytes == '0, "idle with bytes queued")
    `MRFBQ_ASSERT_NOW(a_no_fwd, clk, rst_n, out_valid && (out_data.action == ACT_FILTER || out_data.action == ACT_DROP || out_data.action == ACT_QUEUED), out_data.out_tag == '0 && out_data.out_length == '0 && !out_data.start_service, "non-forwarded item carries a descriptor")

endmodule

bind mac_rx_filter_byte_budget_queue_top mrfbq_checker u_mrfbq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
